[hw/rtl/button_matrix_scanner_macros.svh]
// Assertion macros shared by the button matrix scanner RTL.
`ifndef BUTTON_MATRIX_SCANNER_MACROS_SVH
`define BUTTON_MATRIX_SCANNER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge, quiet while reset is held.
`define BMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define BMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BMS_ASSERT(label, prop, msg)
`define BMS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hw/rtl/bms_pkg.sv]
// Shared types, constants and helpers for the button matrix scanner.
package bms_pkg;

    localparam int MAX_ROWS_DEF    = 8;
    localparam int MAX_COLS_DEF    = 8;
    localparam int BUTTON_BITS_DEF = 64;

    localparam int CNT_W    = 5;   // holds a clamped row or column count, at most 15
    localparam int REGCNT_W = 4;
    localparam int SETTLE_W = 8;
    localparam int LEVEL_W  = 8;
    localparam int MAPIDX_W = 3;
    localparam int NUM_W    = 6;
    localparam int DRIVE_W  = 8;
    localparam int OUTBITS_W = 64;

    localparam logic [REGCNT_W-1:0] ROW_COUNT_RST = 4'd8;
    localparam logic [REGCNT_W-1:0] COL_COUNT_RST = 4'd8;
    localparam logic [SETTLE_W-1:0] SETTLE_RST    = 8'd5;

    typedef enum logic [1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_SETTLE    = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef enum logic {
        PH_HIGH = 1'b0,
        PH_LOW  = 1'b1
    } phase_t;

    typedef struct packed {
        logic               sample;
        logic               done;
        logic [DRIVE_W-1:0] drive;
    } ctrl_t;

    // Count as used by the scan: zero reads as one, large values saturate.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [REGCNT_W-1:0] count,
                                                     input int max_count);
        logic [CNT_W-1:0] wide;
        logic [CNT_W-1:0] lim;
        wide = CNT_W'(count);
        lim  = CNT_W'(max_count);
        if (wide == '0) begin
            return CNT_W'(1);
        end else if (wide > lim) begin
            return lim;
        end
        return wide;
    endfunction

endpackage

[hw/rtl/bms_lane.sv]
// One column lane: button map entries of its column and the hit decode.
module bms_lane #(
    parameter int MAX_ROWS    = bms_pkg::MAX_ROWS_DEF,
    parameter int BUTTON_BITS = bms_pkg::BUTTON_BITS_DEF,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [RW-1:0]            wr_row,
    input  logic [bms_pkg::NUM_W-1:0] wr_num,
    input  logic [RW-1:0]            rd_row,
    input  logic                     sense,
    output logic [BUTTON_BITS-1:0]   hit
);
    import bms_pkg::*;

    logic             valid_reg [MAX_ROWS];
    logic [NUM_W-1:0] num_reg   [MAX_ROWS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (wr_en) begin
            valid_reg[wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            num_reg[wr_row] <= wr_num;
        end
    end

    always_comb begin
        hit = '0;
        if (sense && valid_reg[rd_row]) begin
            hit = BUTTON_BITS'(1) << num_reg[rd_row];
        end
    end

endmodule

[hw/rtl/bms_ctrl.sv]
// Scan sequencer: settle counter, row drive phase and row index.
module bms_ctrl #(
    parameter int MAX_ROWS = bms_pkg::MAX_ROWS_DEF,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         tick,
    input  logic [bms_pkg::SETTLE_W-1:0] settle,
    input  logic [bms_pkg::CNT_W-1:0]    rows_use,
    output logic [RW-1:0]                row_idx,
    output bms_pkg::ctrl_t               ctrl
);
    import bms_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [SETTLE_W-1:0] wait_reg, wait_next;
    logic                settled;
    logic                last_row;

    assign settled  = (wait_reg >= settle);
    assign last_row = (CNT_W'(row_reg) + CNT_W'(1)) >= rows_use;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HIGH;
            row_reg   <= '0;
            wait_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            wait_reg  <= wait_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        wait_next  = wait_reg;
        if (tick) begin
            if (!settled) begin
                wait_next = wait_reg + SETTLE_W'(1);
            end else begin
                wait_next = '0;
                unique case (phase_reg)
                    PH_HIGH: begin
                        phase_next = PH_LOW;
                    end
                    PH_LOW: begin
                        phase_next = PH_HIGH;
                        row_next   = last_row ? '0 : row_reg + RW'(1);
                    end
                    default: begin
                        phase_next = PH_HIGH;
                    end
                endcase
            end
        end
    end

    // Outputs describe the item being accepted now, from the state before it.
    always_comb begin
        ctrl.drive  = '0;
        ctrl.sample = 1'b0;
        ctrl.done   = 1'b0;
        unique case (phase_reg)
            PH_HIGH: begin
                ctrl.drive  = DRIVE_W'(DRIVE_W'(1) << row_reg);
                ctrl.sample = settled;
            end
            PH_LOW: begin
                ctrl.done = settled && last_row;
            end
            default: begin
                ctrl.drive = '0;
            end
        endcase
    end

    assign row_idx = row_reg;

endmodule

[hw/rtl/bms_merge.sv]
// Combines lane hits into the scan accumulator and holds the last full scan.
module bms_merge #(
    parameter int MAX_COLS    = bms_pkg::MAX_COLS_DEF,
    parameter int BUTTON_BITS = bms_pkg::BUTTON_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [BUTTON_BITS-1:0] hits [MAX_COLS],
    input  logic                   sample,
    input  logic                   done,
    output logic [BUTTON_BITS-1:0] scan_bits
);
    import bms_pkg::*;

    logic [BUTTON_BITS-1:0] pending_reg, pending_next;
    logic [BUTTON_BITS-1:0] accum_reg, accum_next;
    logic [BUTTON_BITS-1:0] last_reg, last_next;
    logic [BUTTON_BITS-1:0] merged;
    logic [BUTTON_BITS-1:0] lane_or;

    always_comb begin
        lane_or = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            lane_or = lane_or | hits[c];
        end
    end

    // The hits of the previous sample pass through the pending register before the
    // accumulator takes them, so the completing tick sees them through this bypass.
    assign merged       = accum_reg | pending_reg;
    assign pending_next = sample ? lane_or : '0;
    assign accum_next   = done ? '0 : merged;
    assign last_next    = done ? merged : last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            accum_reg   <= '0;
            last_reg    <= '0;
        end else begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
            last_reg    <= last_next;
        end
    end

    assign scan_bits = last_next;

endmodule

[hw/rtl/button_matrix_scanner.sv]
// The result beat of an item is registered, in the output or the skid register, before it is offered.
// Throughput: one item per cycle while the skid stage is empty; each column lane decodes combinationally.
// A two-entry output register and skid stage keep s_tready high while one result is pending.
// Reset (aresetn low, synchronous) clears the map valid flops at once, the scan state,
// the bitmaps and the counts (8 rows, 8 columns, settle 5); no clearing pass follows.
`include "button_matrix_scanner_macros.svh"

module button_matrix_scanner #(
    parameter int MAX_ROWS    = bms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = bms_pkg::MAX_COLS_DEF,
    parameter int BUTTON_BITS = bms_pkg::BUTTON_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // column_levels[7:0], map_row[10:8], map_col[13:11],
                                  // map_number[19:14], zero [23:20]
    input  logic [0:0]  s_tuser,  // mode[0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // row_drive[7:0], button_bits[71:8]
    output logic        m_tlast,  // scan_done
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bms_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int OUT_W = DRIVE_W + OUTBITS_W;

    // Configuration registers.
    logic [REGCNT_W-1:0] row_count_reg;
    logic [REGCNT_W-1:0] col_count_reg;
    logic [SETTLE_W-1:0] settle_reg;
    reg_idx_t            reg_sel;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            settle_reg    <= SETTLE_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ROW_COUNT: row_count_reg <= pwdata[REGCNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[REGCNT_W-1:0];
                REG_SETTLE:    settle_reg    <= pwdata[SETTLE_W-1:0];
                default:       settle_reg    <= settle_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ROW_COUNT: prdata = 32'(row_count_reg);
            REG_COL_COUNT: prdata = 32'(col_count_reg);
            REG_SETTLE:    prdata = 32'(settle_reg);
            default:       prdata = '0;
        endcase
    end

    // Input beat fields.
    logic                in_accept;
    logic                mode;
    logic [LEVEL_W-1:0]  levels;
    logic [MAPIDX_W-1:0] map_row;
    logic [MAPIDX_W-1:0] map_col;
    logic [NUM_W-1:0]    map_number;
    logic                tick;
    logic                map_ok;
    logic [CNT_W-1:0]    rows_use;
    logic [CNT_W-1:0]    cols_use;

    assign in_accept  = s_tvalid && s_tready;
    assign mode       = s_tuser[0];
    assign levels     = s_tdata[7:0];
    assign map_row    = s_tdata[10:8];
    assign map_col    = s_tdata[13:11];
    assign map_number = s_tdata[19:14];
    assign tick       = in_accept && !mode;
    assign rows_use   = clamp_count(row_count_reg, MAX_ROWS);
    assign cols_use   = clamp_count(col_count_reg, MAX_COLS);
    assign map_ok     = in_accept && mode
                        && (CNT_W'(map_row) < rows_use)
                        && (CNT_W'(map_col) < cols_use)
                        && ({1'b0, map_number} < (NUM_W+1)'(BUTTON_BITS));

    // Sequencer.
    logic [RW-1:0] row_idx;
    ctrl_t         ctrl;

    bms_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick     (tick),
        .settle   (settle_reg),
        .rows_use (rows_use),
        .row_idx  (row_idx),
        .ctrl     (ctrl)
    );

    // Column lanes.
    logic [BUTTON_BITS-1:0] hits [MAX_COLS];

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
        logic sense;
        logic wr_en;

        if (c < LEVEL_W) begin : g_sensed
            assign sense = levels[c] && (CNT_W'(c) < cols_use);
        end else begin : g_unsensed
            assign sense = 1'b0;
        end

        assign wr_en = map_ok && (CNT_W'(map_col) == CNT_W'(c));

        bms_lane #(
            .MAX_ROWS    (MAX_ROWS),
            .BUTTON_BITS (BUTTON_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_en),
            .wr_row  (RW'(map_row)),
            .wr_num  (map_number),
            .rd_row  (row_idx),
            .sense   (sense),
            .hit     (hits[c])
        );
    end

    // Merge stage.
    logic [BUTTON_BITS-1:0] scan_bits;

    bms_merge #(
        .MAX_COLS    (MAX_COLS),
        .BUTTON_BITS (BUTTON_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hits      (hits),
        .sample    (tick && ctrl.sample),
        .done      (tick && ctrl.done),
        .scan_bits (scan_bits)
    );

    // Result beat and skid stage.
    logic [OUT_W-1:0] res_data;
    logic             res_last;
    logic             out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;
    logic             out_last_reg, skid_last_reg;
    logic             out_take;

    assign res_data = {OUTBITS_W'(scan_bits), ctrl.drive};
    assign res_last = tick && ctrl.done;
    assign out_take = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_accept;
            end
        end else if (in_accept) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg && out_take) begin
            out_data_reg <= skid_data_reg;
            out_last_reg <= skid_last_reg;
        end else if (in_accept && (out_take || !out_valid_reg)) begin
            out_data_reg <= res_data;
            out_last_reg <= res_last;
        end
        if (in_accept && out_valid_reg && !out_take) begin
            skid_data_reg <= res_data;
            skid_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `BMS_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full, output empty")
    `BMS_ASSERT(a_drive_onehot0, $onehot0(ctrl.drive), "row drive is not one-hot or zero")
    `BMS_ASSERT(a_done_rows_low, tick && ctrl.done |-> ctrl.drive == '0, "row driven at scan end")
    `BMS_ASSERT(a_no_sample_and_done, !(ctrl.sample && ctrl.done), "sample and done together")

endmodule
